/* hdl/wwf_pkg.sv */
// Shared types, codes and constants for the weighted window FIR filter.
package wwf_pkg;

    // Command codes carried in the input beat
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEFF  = 1'b1;

    // Filter mode codes
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_GAUSS = 2'd1;
    localparam logic [1:0] MODE_LWMA  = 2'd2;

    // Weight shape codes
    localparam logic [1:0] SHAPE_LINEAR  = 2'd0;
    localparam logic [1:0] SHAPE_SQUARED = 2'd1;
    localparam logic [1:0] SHAPE_CUBIC   = 2'd2;

    // Configuration register indexes and port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_SHAPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd2;
    localparam logic [4:0] WINDOW_RESET = 5'd16;

    // Field widths
    localparam int SAMPLE_W = 32;
    localparam int COEFF_W  = 16;
    localparam int CIDX_W   = 4;

    // Gaussian coefficients are Q.15, so sums scale back by 2^15
    localparam int GAUSS_DEN = 32768;

    // Divider: 32 quotient bits, two per step
    localparam int QUOT_W        = 32;
    localparam int BITS_PER_STEP = 2;
    localparam int DIV_STEPS     = QUOT_W / BITS_PER_STEP;
    localparam int DIV_STEP_W    = $clog2(DIV_STEPS);

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                        cmd;
        logic signed [SAMPLE_W-1:0]  sample;
        logic        [CIDX_W-1:0]    coeff_index;
        logic signed [COEFF_W-1:0]   coeff_value;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  filtered;
        logic                        was_filtered;
    } out_t;

    typedef struct packed {
        logic        start;
        logic        gauss;
        logic [1:0]  shape;
    } mac_ctl_t;

    typedef struct packed {
        logic                        en;
        logic        [CIDX_W-1:0]    index;
        logic signed [COEFF_W-1:0]   value;
    } coef_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } fsm_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_SETUP,
        DIV_ITER,
        DIV_DONE
    } div_state_t;

endpackage

/* hdl/wwf_mac.sv */
// Sample and coefficient memories with the tap-walking multiply-accumulate unit.
module wwf_mac #(
    parameter  int MAX_TAPS = 16,
    localparam int AW       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
    localparam int NW       = $clog2(MAX_TAPS + 1),
    localparam int WTW      = 3 * NW,
    localparam int MW       = (WTW + 1 > wwf_pkg::COEFF_W + 1) ? WTW + 1 : wwf_pkg::COEFF_W + 1,
    localparam int PROD_W   = MW + wwf_pkg::SAMPLE_W,
    localparam int ACC_W    = PROD_W + NW
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  wwf_pkg::mac_ctl_t               ctl,
    input  logic [AW-1:0]                   start_addr,
    input  logic [NW-1:0]                   taps,
    input  logic                            smp_we,
    input  logic [AW-1:0]                   smp_addr,
    input  logic signed [wwf_pkg::SAMPLE_W-1:0] smp_data,
    input  wwf_pkg::coef_wr_t               coef_wr,
    output logic                            done,
    output logic signed [ACC_W-1:0]         acc
);

    localparam int CIW    = (AW > wwf_pkg::CIDX_W) ? AW : wwf_pkg::CIDX_W;

    logic signed [wwf_pkg::SAMPLE_W-1:0] smp_mem [0:MAX_TAPS-1];
    logic signed [wwf_pkg::COEFF_W-1:0]  coef_mem [0:MAX_TAPS-1];
    logic [MAX_TAPS-1:0]                 cvalid_reg;

    logic                 busy_reg, v1_reg, v2_reg, done_reg;
    logic                 gauss_reg;
    logic [1:0]           shape_reg;
    logic [NW-1:0]        taps_reg, cnt_reg, p_reg;
    logic [2*NW-1:0]      p2_reg;
    logic [WTW-1:0]       p3_reg, w1_reg;
    logic [AW-1:0]        rd_ptr_reg;
    logic signed [wwf_pkg::SAMPLE_W-1:0] smp_q_reg;
    logic signed [wwf_pkg::COEFF_W-1:0]  coef_q_reg;
    logic                 cval_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                 issue;
    logic [CIW-1:0]       cidx;
    logic [AW-1:0]        coef_addr;
    logic                 coef_ok;
    logic [AW-1:0]        rd_ptr_next;
    logic [2*NW-1:0]      p2_next;
    logic [WTW-1:0]       p3_next;
    logic [WTW-1:0]       weight;
    logic signed [MW-1:0] mul_a;

    assign issue     = busy_reg && (cnt_reg != taps_reg);
    assign cidx      = CIW'(coef_wr.index);
    assign coef_addr = cidx[AW-1:0];
    assign coef_ok   = coef_wr.en && (32'(coef_wr.index) < 32'(MAX_TAPS));

    assign rd_ptr_next = (rd_ptr_reg == AW'(MAX_TAPS - 1)) ? '0 : rd_ptr_reg + AW'(1);

    // Running powers of the tap weight: (p+1)^2 and (p+1)^3 by differences
    assign p2_next = p2_reg + (2*NW)'({p_reg, 1'b0}) + (2*NW)'(1);
    assign p3_next = p3_reg + WTW'({p2_reg, 1'b0}) + WTW'(p2_reg)
                   + WTW'({p_reg, 1'b0}) + WTW'(p_reg) + WTW'(1);

    always_comb begin
        case (shape_reg)
            wwf_pkg::SHAPE_SQUARED: weight = WTW'(p2_reg);
            wwf_pkg::SHAPE_CUBIC:   weight = p3_reg;
            default:                weight = WTW'(p_reg);
        endcase
    end

    // Unwritten coefficients read as zero
    always_comb begin
        if (gauss_reg) begin
            mul_a = cval_q_reg ? {{(MW - wwf_pkg::COEFF_W){coef_q_reg[wwf_pkg::COEFF_W-1]}},
                                  coef_q_reg} : '0;
        end else begin
            mul_a = {{(MW - WTW){1'b0}}, w1_reg};
        end
    end

    // Memories: one write and one registered read each
    always_ff @(posedge aclk) begin
        if (smp_we) begin
            smp_mem[smp_addr] <= smp_data;
        end
        if (coef_ok) begin
            coef_mem[coef_addr] <= coef_wr.value;
        end
        smp_q_reg  <= smp_mem[rd_ptr_reg];
        coef_q_reg <= coef_mem[cnt_reg[AW-1:0]];
        cval_q_reg <= cvalid_reg[cnt_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            done_reg   <= 1'b0;
            cvalid_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            v1_reg   <= issue;
            v2_reg   <= v1_reg;
            if (coef_ok) begin
                cvalid_reg[coef_addr] <= 1'b1;
            end
            if (ctl.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && !issue && !v1_reg && !v2_reg) begin
                // pipeline drained, last product is in the accumulator
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            gauss_reg  <= ctl.gauss;
            shape_reg  <= ctl.shape;
            taps_reg   <= taps;
            cnt_reg    <= '0;
            rd_ptr_reg <= start_addr;
            p_reg      <= NW'(1);
            p2_reg     <= (2*NW)'(1);
            p3_reg     <= WTW'(1);
        end else if (issue) begin
            cnt_reg    <= cnt_reg + NW'(1);
            rd_ptr_reg <= rd_ptr_next;
            p_reg      <= p_reg + NW'(1);
            p2_reg     <= p2_next;
            p3_reg     <= p3_next;
            w1_reg     <= weight;
        end
        if (v1_reg) begin
            prod_reg <= mul_a * smp_q_reg;
        end
        if (ctl.start) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

/* hdl/wwf_div.sv */
// Signed-by-unsigned divider, two quotient bits per cycle, saturating to 32 bits.
module wwf_div #(
    parameter int ACC_W = 54,
    parameter int DEN_W = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [ACC_W-1:0]             dividend,
    input  logic [DEN_W-1:0]                    divisor,
    output logic                                done,
    output logic signed [wwf_pkg::QUOT_W-1:0]   quotient
);

    localparam int QW   = wwf_pkg::QUOT_W;
    localparam int HI_W = (ACC_W - QW > DEN_W) ? ACC_W - QW : DEN_W;

    wwf_pkg::div_state_t state_reg, state_next;

    logic [wwf_pkg::DIV_STEP_W-1:0] step_reg;
    logic [ACC_W-1:0]  mag_reg;
    logic              neg_reg;
    logic              ovf_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [QW-1:0]     low_reg, low_next;
    logic [QW-1:0]     q_reg, q_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wwf_pkg::DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        done       = 1'b0;
        case (state_reg)
            wwf_pkg::DIV_IDLE: begin
                if (start) begin
                    state_next = wwf_pkg::DIV_SETUP;
                end
            end
            wwf_pkg::DIV_SETUP: begin
                state_next = wwf_pkg::DIV_ITER;
            end
            wwf_pkg::DIV_ITER: begin
                if (step_reg == wwf_pkg::DIV_STEP_W'(wwf_pkg::DIV_STEPS - 1)) begin
                    state_next = wwf_pkg::DIV_DONE;
                end
            end
            wwf_pkg::DIV_DONE: begin
                done       = 1'b1;
                state_next = wwf_pkg::DIV_IDLE;
            end
            default: state_next = wwf_pkg::DIV_IDLE;
        endcase
    end

    // Restoring steps: shift in the next dividend bit, subtract when it fits
    always_comb begin
        logic [DEN_W:0] r2;
        rem_next = rem_reg;
        low_next = low_reg;
        q_next   = q_reg;
        for (int j = 0; j < wwf_pkg::BITS_PER_STEP; j++) begin
            r2       = {rem_next, low_next[QW-1]};
            low_next = {low_next[QW-2:0], 1'b0};
            if (r2 >= {1'b0, den_reg}) begin
                rem_next = DEN_W'(r2 - {1'b0, den_reg});
                q_next   = {q_next[QW-2:0], 1'b1};
            end else begin
                rem_next = DEN_W'(r2);
                q_next   = {q_next[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            wwf_pkg::DIV_IDLE: begin
                if (start) begin
                    mag_reg <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
                    neg_reg <= dividend[ACC_W-1];
                    den_reg <= divisor;
                end
            end
            wwf_pkg::DIV_SETUP: begin
                // quotient of 2^32 or more saturates; otherwise the high part
                // is below the divisor and seeds the remainder
                ovf_reg  <= HI_W'(mag_reg[ACC_W-1:QW]) >= HI_W'(den_reg);
                rem_reg  <= DEN_W'(mag_reg[ACC_W-1:QW]);
                low_reg  <= mag_reg[QW-1:0];
                q_reg    <= '0;
                step_reg <= '0;
            end
            wwf_pkg::DIV_ITER: begin
                rem_reg  <= rem_next;
                low_reg  <= low_next;
                q_reg    <= q_next;
                step_reg <= step_reg + wwf_pkg::DIV_STEP_W'(1);
            end
            default: ;
        endcase
    end

    always_comb begin
        if (neg_reg) begin
            if (ovf_reg || (q_reg > QW'(unsigned'(wwf_pkg::SAT_MIN)))) begin
                quotient = wwf_pkg::SAT_MIN;
            end else begin
                quotient = -$signed(q_reg);
            end
        end else begin
            if (ovf_reg || q_reg[QW-1]) begin
                quotient = wwf_pkg::SAT_MAX;
            end else begin
                quotient = $signed(q_reg);
            end
        end
    end

endmodule

/* hdl/weighted_window_fir_filter.sv */
// Top level: configuration, sample sequencing, divider hookup and output register.
//
//  channel   direction  handshake            beat
//  s_        in         s_valid / s_ready    wwf_pkg::in_t  (sample or coefficient)
//  m_        out        m_valid / m_ready    wwf_pkg::out_t (one per sample)
//  cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// A coefficient beat is written in its accept cycle; the block stays ready.
// A sample that is passed through goes by way of ST_OUT into the output register.
// A filtered sample walks its N taps over the one read port of each memory, then
// passes the multiply pipeline and the divider, with control states in between.
// Input is taken again once the result sits in the output register; a stalled output
// holds the next result in the sequencer. Reset clears control state and the
// coefficient valid bits; no clearing pass is needed.
module weighted_window_fir_filter #(
    parameter int MAX_TAPS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  wwf_pkg::in_t                        s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output wwf_pkg::out_t                       m_data,
    input  logic                                cfg_we,
    input  logic [wwf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wwf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int NW     = $clog2(MAX_TAPS + 1);
    localparam int WTW    = 3 * NW;
    localparam int MW     = (WTW + 1 > wwf_pkg::COEFF_W + 1) ? WTW + 1 : wwf_pkg::COEFF_W + 1;
    localparam int PROD_W = MW + wwf_pkg::SAMPLE_W;
    localparam int ACC_W  = PROD_W + NW;
    localparam int DEN_W  = (4 * NW > 16) ? 4 * NW : 16;

    wwf_pkg::fsm_state_t state_reg, state_next;

    logic [1:0]        mode_reg, shape_reg;
    logic [4:0]        wlen_reg;
    logic [NW-1:0]     seen_reg, seen_inc;
    logic [AW-1:0]     wp_reg, wp_inc;
    logic [NW-1:0]     taps;
    logic [NW:0]       ptr_sum, oldest;
    logic [AW-1:0]     start_addr;
    logic              accept, is_sample, do_filt;
    logic              div_start, out_load;
    logic [DEN_W-1:0]  den_reg;
    logic [1:0]        den_cnt_reg;
    wwf_pkg::out_t     res_reg;
    logic              m_valid_reg;
    wwf_pkg::out_t     m_data_reg;

    wwf_pkg::mac_ctl_t  mac_ctl;
    wwf_pkg::coef_wr_t  coef_wr;
    logic               mac_done;
    logic signed [ACC_W-1:0] mac_acc;
    logic               div_done;
    logic signed [wwf_pkg::QUOT_W-1:0] div_q;

    // Effective tap count: zero counts as one, clip at the line length
    always_comb begin
        if (wlen_reg == '0) begin
            taps = NW'(1);
        end else if (32'(wlen_reg) > 32'(MAX_TAPS)) begin
            taps = NW'(MAX_TAPS);
        end else begin
            taps = NW'(wlen_reg);
        end
    end

    assign seen_inc = (32'(seen_reg) == 32'(MAX_TAPS)) ? seen_reg : seen_reg + NW'(1);
    assign wp_inc   = (wp_reg == AW'(MAX_TAPS - 1)) ? '0 : wp_reg + AW'(1);

    // Oldest tap of the window once the new sample lands at wp_reg
    assign ptr_sum = (NW+1)'(wp_reg) + (NW+1)'(1);
    always_comb begin
        if (ptr_sum >= (NW+1)'(taps)) begin
            oldest = ptr_sum - (NW+1)'(taps);
        end else begin
            oldest = ptr_sum + (NW+1)'(MAX_TAPS) - (NW+1)'(taps);
        end
    end
    assign start_addr = oldest[AW-1:0];

    assign accept    = s_valid && s_ready;
    assign is_sample = (s_data.cmd == wwf_pkg::CMD_SAMPLE);
    assign do_filt   = (seen_inc >= taps) &&
                       ((mode_reg == wwf_pkg::MODE_GAUSS) || (mode_reg == wwf_pkg::MODE_LWMA));

    assign mac_ctl.start = accept && is_sample && do_filt;
    assign mac_ctl.gauss = (mode_reg == wwf_pkg::MODE_GAUSS);
    assign mac_ctl.shape = shape_reg;

    assign coef_wr.en    = accept && !is_sample;
    assign coef_wr.index = s_data.coeff_index;
    assign coef_wr.value = s_data.coeff_value;

    wwf_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (mac_ctl),
        .start_addr (start_addr),
        .taps       (taps),
        .smp_we     (accept && is_sample),
        .smp_addr   (wp_reg),
        .smp_data   (s_data.sample),
        .coef_wr    (coef_wr),
        .done       (mac_done),
        .acc        (mac_acc)
    );

    wwf_div #(
        .ACC_W (ACC_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mac_acc),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wwf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            wwf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && is_sample) begin
                    if (do_filt) begin
                        state_next = wwf_pkg::ST_MAC;
                    end else begin
                        state_next = wwf_pkg::ST_OUT;
                    end
                end
            end
            wwf_pkg::ST_MAC: begin
                if (mac_done) begin
                    div_start  = 1'b1;
                    state_next = wwf_pkg::ST_DIV;
                end
            end
            wwf_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = wwf_pkg::ST_OUT;
                end
            end
            wwf_pkg::ST_OUT: begin
                // hold the result until the output register frees up
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = wwf_pkg::ST_IDLE;
                end
            end
            default: state_next = wwf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= wwf_pkg::MODE_PASS;
            shape_reg   <= wwf_pkg::SHAPE_LINEAR;
            wlen_reg    <= wwf_pkg::WINDOW_RESET;
            seen_reg    <= '0;
            wp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    wwf_pkg::CFG_FILTER_MODE:   mode_reg  <= cfg_wdata[1:0];
                    wwf_pkg::CFG_WEIGHT_SHAPE:  shape_reg <= cfg_wdata[1:0];
                    wwf_pkg::CFG_WINDOW_LENGTH: wlen_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept && is_sample) begin
                seen_reg <= seen_inc;
                wp_reg   <= wp_inc;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_sample) begin
            res_reg.filtered     <= s_data.sample;
            res_reg.was_filtered <= 1'b0;
            if (mode_reg == wwf_pkg::MODE_GAUSS) begin
                den_reg     <= DEN_W'(wwf_pkg::GAUSS_DEN);
                den_cnt_reg <= 2'd0;
            end else begin
                // N^(k+1): start at N, multiply by N k more times
                den_reg <= DEN_W'(taps);
                case (shape_reg)
                    wwf_pkg::SHAPE_SQUARED: den_cnt_reg <= 2'd2;
                    wwf_pkg::SHAPE_CUBIC:   den_cnt_reg <= 2'd3;
                    default:                den_cnt_reg <= 2'd1;
                endcase
            end
        end else if ((state_reg == wwf_pkg::ST_MAC) && (den_cnt_reg != 2'd0)) begin
            den_reg     <= DEN_W'(den_reg * taps);
            den_cnt_reg <= den_cnt_reg - 2'd1;
        end
        if (div_done) begin
            res_reg.filtered     <= div_q;
            res_reg.was_filtered <= 1'b1;
        end
        if (out_load) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_mac_done_in_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> (state_reg == wwf_pkg::ST_MAC))
        else $error("tap walk finished outside the accumulate phase");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == wwf_pkg::ST_DIV))
        else $error("divider finished outside the divide phase");

    a_coef_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.cmd == wwf_pkg::CMD_COEFF)) |=> (state_reg == wwf_pkg::ST_IDLE))
        else $error("coefficient beat started a result");

    a_den_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (den_cnt_reg == 2'd0))
        else $error("divisor not complete when the divide starts");

endmodule

/* bench/tb_weighted_window_fir_filter.sv */
// Self-checking testbench for the weighted window FIR filter: directed cases, random phases.
`timescale 1ns / 100ps

module tb_weighted_window_fir_filter;
    import wwf_pkg::*;

    localparam int TAPS          = 16;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int LONG_HOLD     = 300;
    localparam int BLOCK_ITEMS   = 56;

    // Codes the package leaves unnamed
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
    localparam logic [1:0]           MODE_SPARE  = 2'd3;
    localparam logic [1:0]           SHAPE_SPARE = 2'd3;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_valid   = 1'b0;
    logic         s_ready;
    in_t          s_data    = '0;
    logic         m_valid;
    logic         m_ready   = 1'b0;
    out_t         m_data;
    logic         cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Filter state mirrored by the testbench
    logic signed [SAMPLE_W-1:0] delay_line [TAPS];
    logic signed [COEFF_W-1:0]  gauss_taps [TAPS];
    int unsigned                fill_count;
    logic [1:0]                 cur_mode;
    logic [1:0]                 cur_shape;
    logic [4:0]                 cur_length;

    out_t        pending_filtered [$];
    int unsigned err_count     = 0;
    int unsigned cycle_count   = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served  = 0;
    int unsigned hold_left     = 0;

    weighted_window_fir_filter #(.MAX_TAPS(TAPS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // Work out the result of one accepted beat, if it has one
    task automatic predict_beat(input in_t beat);
        int     n;
        int     base;
        int     k;
        longint acc;
        longint den;
        longint w;
        longint res;
        out_t   r;
        if (beat.cmd == CMD_COEFF) begin
            gauss_taps[beat.coeff_index] = beat.coeff_value;
            return;
        end
        for (int i = 0; i < TAPS - 1; i++) delay_line[i] = delay_line[i + 1];
        delay_line[TAPS - 1] = beat.sample;
        if (fill_count < TAPS) fill_count++;

        n = (cur_length == 0) ? 1 : (cur_length > TAPS) ? TAPS : int'(cur_length);
        base = TAPS - n;
        res = longint'(beat.sample);
        r.was_filtered = 1'b0;
        if (fill_count >= n && (cur_mode == MODE_GAUSS || cur_mode == MODE_LWMA)) begin
            acc = 0;
            r.was_filtered = 1'b1;
            if (cur_mode == MODE_GAUSS) begin
                for (int i = 0; i < n; i++)
                    acc += longint'(gauss_taps[i]) * longint'(delay_line[base + i]);
                res = acc / GAUSS_DEN;
            end else begin
                // shape 3 falls back to linear
                k = (cur_shape == SHAPE_SQUARED) ? 2 : (cur_shape == SHAPE_CUBIC) ? 3 : 1;
                den = n;
                repeat (k) den *= n;
                for (int i = 0; i < n; i++) begin
                    w = 1;
                    repeat (k) w *= (i + 1);
                    acc += w * longint'(delay_line[base + i]);
                end
                res = acc / den;
            end
            if (res > longint'(SAT_MAX)) res = longint'(SAT_MAX);
            if (res < longint'(SAT_MIN)) res = longint'(SAT_MIN);
        end
        r.filtered = res[SAMPLE_W-1:0];
        pending_filtered.push_back(r);
    endtask

    // Compare every result beat with the oldest prediction
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_filtered.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_data));
            end else begin
                want = pending_filtered.pop_front();
                if (m_data.filtered !== want.filtered)
                    report_mismatch($sformatf("filtered %h, want %h",
                                              m_data.filtered, want.filtered));
                if (m_data.was_filtered !== want.was_filtered)
                    report_mismatch($sformatf("was_filtered %b, want %b",
                                              m_data.was_filtered, want.was_filtered));
            end
        end
    end

    // Result side: random stalls, plus a long hold when one is requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    task automatic send_beat(input in_t beat);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        predict_beat(beat);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        in_t beat;
        beat.cmd         = CMD_SAMPLE;
        beat.sample      = value;
        beat.coeff_index = CIDX_W'($urandom);
        beat.coeff_value = COEFF_W'($urandom);
        send_beat(beat);
    endtask

    task automatic send_coeff(input logic [CIDX_W-1:0] idx,
                              input logic signed [COEFF_W-1:0] value);
        in_t beat;
        beat.cmd         = CMD_COEFF;
        beat.sample      = SAMPLE_W'($urandom);
        beat.coeff_index = idx;
        beat.coeff_value = value;
        send_beat(beat);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return SAMPLE_W'($urandom_range(0, 4000)) - SAMPLE_W'(2000);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    // Stop offering, wait for every result, then let the block settle
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_filtered.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_FILTER_MODE:   cur_mode   = value[1:0];
            CFG_WEIGHT_SHAPE:  cur_shape  = value[1:0];
            CFG_WINDOW_LENGTH: cur_length = value[4:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [1:0] shape,
                              input logic [4:0] len);
        drain_results();
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_WEIGHT_SHAPE, CFG_DATA_W'(shape));
        write_reg(CFG_WINDOW_LENGTH, len);
    endtask

    // Reset defaults pass through; weighted mode waits for the window to fill
    task automatic test_window_fill();
        send_sample(SAT_MAX);
        send_coeff(4'd15, 16'sh8000);
        drain_results();
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_LWMA));
        send_sample(SAT_MIN);
        send_sample(-32'sd1);
        drain_results();
        write_reg(CFG_WINDOW_LENGTH, 5'd3);
        send_sample(32'sd0);
    endtask

    task automatic test_gauss_extremes();
        set_config(MODE_GAUSS, SHAPE_LINEAR, 5'd2);
        send_coeff(4'd0, 16'sh7FFF);
        send_coeff(4'd1, 16'sh7FFF);
        send_sample(SAT_MAX);
        send_sample(SAT_MAX);
        send_sample(SAT_MIN);
        send_sample(SAT_MIN);
        // zero length acts as one tap; small products truncate toward zero
        set_config(MODE_GAUSS, SHAPE_LINEAR, 5'd0);
        send_sample(32'sd1);
        send_sample(-32'sd1);
        send_coeff(4'd0, 16'sh8000);
        send_sample(SAT_MIN);
    endtask

    task automatic test_register_edges();
        set_config(MODE_LWMA, SHAPE_SPARE, 5'd31);
        send_sample(-32'sd1);
        set_config(MODE_LWMA, SHAPE_CUBIC, 5'd16);
        send_sample(SAT_MIN);
        set_config(MODE_LWMA, SHAPE_SQUARED, 5'd16);
        send_sample(SAT_MAX);
        set_config(MODE_SPARE, SHAPE_CUBIC, 5'd16);
        send_sample(32'sd5);
        drain_results();
        write_reg(CFG_SPARE, 5'h1F);
        send_sample(32'sd7);
    endtask

    // Hold the result side long enough that the block stops taking input
    task automatic test_backpressure();
        set_config(MODE_LWMA, SHAPE_SQUARED, 5'd16);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_requests++;
        repeat (30) send_sample(pick_sample());
        drain_results();
    endtask

    task automatic test_random_phase(input int unsigned src_pct, input int unsigned sink_pct,
                                     input bit sweep_extremes);
        logic [1:0] mode;
        logic [4:0] len;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int blk = 0; blk < 4; blk++) begin
            if (sweep_extremes) begin
                case (blk)
                    0: set_config(MODE_LWMA, SHAPE_CUBIC, 5'd16);
                    1: set_config(MODE_GAUSS, SHAPE_LINEAR, 5'd16);
                    2: set_config(MODE_LWMA, SHAPE_LINEAR, 5'd1);
                    default: set_config(MODE_GAUSS, SHAPE_SQUARED, 5'd1);
                endcase
            end else begin
                case ($urandom_range(0, 9))
                    0: mode = MODE_PASS;
                    1: mode = MODE_SPARE;
                    2, 3, 4, 5: mode = MODE_GAUSS;
                    default: mode = MODE_LWMA;
                endcase
                len = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
                set_config(mode, 2'($urandom), len);
            end
            repeat (BLOCK_ITEMS) begin
                if ($urandom_range(0, 99) < 20)
                    send_coeff(CIDX_W'($urandom), pick_coeff());
                else
                    send_sample(pick_sample());
            end
        end
    endtask

    initial begin
        for (int i = 0; i < TAPS; i++) begin
            delay_line[i] = '0;
            gauss_taps[i] = '0;
        end
        fill_count = 0;
        cur_mode   = MODE_PASS;
        cur_shape  = SHAPE_LINEAR;
        cur_length = WINDOW_RESET;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        test_window_fill();
        test_gauss_extremes();
        test_register_edges();
        test_random_phase(0, 0, 1'b1);
        test_backpressure();
        test_random_phase(70, 0, 1'b0);
        test_random_phase(0, 70, 1'b0);
        test_random_phase(29, 29, 1'b0);
        drain_results();

        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
